[rtl/core/hsfd_pkg.sv]
// Shared types, constants and the CRC-8 byte update for the frame decoder.
`timescale 1ns / 1ps

package hsfd_pkg;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// Conversion constants: hundredths per full-scale word, and the temperature offset.
	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [13:0] HUM_SCALE   = 14'd10000;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;

	// One complete response, as handed from the byte front end to the converter.
	typedef struct packed {
		logic [15:0] raw_temperature;
		logic [15:0] raw_humidity;
		logic        temperature_crc_ok;
		logic        humidity_crc_ok;
	} frame_t;

	// CRC-8, MSB first, no final xor: fold in one byte.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[rtl/core/hsfd_front.sv]
// Byte front end: tracks frame position, runs the CRC and assembles the raw words.
`timescale 1ns / 1ps

module hsfd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           rx_byte,
	input  logic                 frame_start,
	output logic                 push,
	output hsfd_pkg::frame_t     push_frame
);

	typedef enum logic [2:0] {
		POS_TEMP_HI  = 3'd0,
		POS_TEMP_LO  = 3'd1,
		POS_TEMP_CRC = 3'd2,
		POS_HUM_HI   = 3'd3,
		POS_HUM_LO   = 3'd4,
		POS_HUM_CRC  = 3'd5
	} pos_t;

	pos_t        pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_word_q;
	logic [15:0] hum_word_q;
	logic        temp_ok_q;

	pos_t        pos_sel;
	logic [7:0]  crc_seeded;
	logic [7:0]  crc_running;

	// A start flag forces byte zero whatever the position was.
	assign pos_sel     = frame_start ? POS_TEMP_HI : pos_q;
	assign crc_seeded  = hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, rx_byte);
	assign crc_running = hsfd_pkg::crc8_byte(crc_q, rx_byte);

	assign push = take && (pos_sel == POS_HUM_CRC);
	assign push_frame = '{
		raw_temperature:    temp_word_q,
		raw_humidity:       hum_word_q,
		temperature_crc_ok: temp_ok_q,
		humidity_crc_ok:    (crc_q == rx_byte)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_TEMP_HI;
			crc_q       <= hsfd_pkg::CRC_INIT;
			temp_word_q <= '0;
			hum_word_q  <= '0;
			temp_ok_q   <= 1'b0;
		end else if (take) begin
			unique case (pos_sel)
				POS_TEMP_LO: begin
					crc_q       <= crc_running;
					temp_word_q <= {temp_word_q[15:8], rx_byte};
					pos_q       <= POS_TEMP_CRC;
				end
				POS_TEMP_CRC: begin
					temp_ok_q <= (crc_q == rx_byte);
					crc_q     <= hsfd_pkg::CRC_INIT;
					pos_q     <= POS_HUM_HI;
				end
				POS_HUM_HI: begin
					crc_q      <= crc_seeded;
					hum_word_q <= {rx_byte, 8'h00};
					pos_q      <= POS_HUM_LO;
				end
				POS_HUM_LO: begin
					crc_q      <= crc_running;
					hum_word_q <= {hum_word_q[15:8], rx_byte};
					pos_q      <= POS_HUM_CRC;
				end
				POS_HUM_CRC: begin
					crc_q <= hsfd_pkg::CRC_INIT;
					pos_q <= POS_TEMP_HI;
				end
				default: begin
					// byte zero, and the unused position codes
					crc_q       <= crc_seeded;
					temp_word_q <= {rx_byte, 8'h00};
					pos_q       <= POS_TEMP_LO;
				end
			endcase
		end
	end

endmodule

[rtl/core/hsfd_queue.sv]
// Short frame queue between the byte front end and the converter.
`timescale 1ns / 1ps

module hsfd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hsfd_pkg::frame_t     push_frame,
	input  logic                 pop,
	output logic                 full,
	output logic                 nonempty,
	output hsfd_pkg::frame_t     head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hsfd_pkg::frame_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/hsfd_convert.sv]
// Converter: scales the raw words to hundredths and holds the result for transfer.
`timescale 1ns / 1ps

module hsfd_convert (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 avail,
	input  hsfd_pkg::frame_t     frame,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [14:0]   temperature_centi_c,
	output logic [13:0]          humidity_centi_pct,
	output logic [15:0]          raw_temperature,
	output logic [15:0]          raw_humidity,
	output logic                 temperature_crc_ok,
	output logic                 humidity_crc_ok,
	output logic                 frame_ok
);

	logic             valid_s1;
	hsfd_pkg::frame_t frame_s1;
	logic [30:0]      temp_prod_s1;
	logic [29:0]      hum_prod_s1;

	logic             valid_s2;
	logic [14:0]      temp_s2;
	logic [13:0]      hum_s2;
	hsfd_pkg::frame_t frame_s2;

	logic adv_s2;
	logic adv_s1;

	assign adv_s2 = !valid_s2 || !out_stall;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop    = avail && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= avail;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_s1     <= frame;
			temp_prod_s1 <= 31'(frame.raw_temperature) * 31'(hsfd_pkg::TEMP_SCALE);
			hum_prod_s1  <= 30'(frame.raw_humidity) * 30'(hsfd_pkg::HUM_SCALE);
		end
		if (adv_s2 && valid_s1) begin
			frame_s2 <= frame_s1;
			// floor by 65536 is the upper half; the offset wraps into two's complement
			temp_s2  <= temp_prod_s1[30:16] - hsfd_pkg::TEMP_OFFSET;
			hum_s2   <= hum_prod_s1[29:16];
		end
	end

	assign out_valid           = valid_s2;
	assign temperature_centi_c = signed'(temp_s2);
	assign humidity_centi_pct  = hum_s2;
	assign raw_temperature     = frame_s2.raw_temperature;
	assign raw_humidity        = frame_s2.raw_humidity;
	assign temperature_crc_ok  = frame_s2.temperature_crc_ok;
	assign humidity_crc_ok     = frame_s2.humidity_crc_ok;
	assign frame_ok            = frame_s2.temperature_crc_ok && frame_s2.humidity_crc_ok;

endmodule

[rtl/core/humidity_sensor_frame_decoder.sv]
// Top level of the humidity sensor frame decoder.
//
// Takes one response byte per cycle while in_stall is low (rx_byte, with frame_start marking
// byte zero) and, after the sixth byte of a frame, delivers one result: both CRC-8 verdicts
// (poly 0x31, init 0xFF), the raw temperature and humidity words, and the values converted to
// hundredths of a degree and of a percent. A failed checksum still gives a result, with
// frame_ok low. A start flag in mid-frame drops the partial frame. The byte side runs at one
// byte per clock while in_stall is low; results pass through a two-stage multiply pipeline
// (s1, s2). Completed frames wait in a queue of QUEUE_DEPTH entries (at least 2), so in_stall
// rises only once that queue is full, which happens only while the result side holds out_stall.
`timescale 1ns / 1ps

module humidity_sensor_frame_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rx_byte,
	input  logic                 frame_start,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [14:0]   temperature_centi_c,
	output logic [13:0]          humidity_centi_pct,
	output logic [15:0]          raw_temperature,
	output logic [15:0]          raw_humidity,
	output logic                 temperature_crc_ok,
	output logic                 humidity_crc_ok,
	output logic                 frame_ok
);

	logic             take;
	logic             push;
	hsfd_pkg::frame_t push_frame;
	logic             q_full;
	logic             q_nonempty;
	hsfd_pkg::frame_t q_head;
	logic             pop;

	assign in_stall = q_full;
	assign take     = in_valid && !in_stall;

	hsfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.push        (push),
		.push_frame  (push_frame)
	);

	hsfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.full       (q_full),
		.nonempty   (q_nonempty),
		.head       (q_head)
	);

	hsfd_convert u_convert (
		.clk                 (clk),
		.arst_n              (arst_n),
		.avail               (q_nonempty),
		.frame               (q_head),
		.pop                 (pop),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.temperature_centi_c (temperature_centi_c),
		.humidity_centi_pct  (humidity_centi_pct),
		.raw_temperature     (raw_temperature),
		.raw_humidity        (raw_humidity),
		.temperature_crc_ok  (temperature_crc_ok),
		.humidity_crc_ok     (humidity_crc_ok),
		.frame_ok            (frame_ok)
	);

endmodule

[tb/tb_humidity_sensor_frame_decoder.sv]
// Self-checking testbench for the humidity sensor frame decoder: directed frames, then random traffic.
`timescale 1ns / 1ps

module tb_humidity_sensor_frame_decoder;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 16;
	localparam int RANDOM_BYTES  = 500;
	localparam int REPORT_BUDGET = 10;

	typedef enum logic [2:0] {
		POS_T_HI,
		POS_T_LO,
		POS_T_CRC,
		POS_H_HI,
		POS_H_LO,
		POS_H_CRC
	} byte_pos_t;

	typedef struct packed {
		logic signed [14:0] temp_centi;
		logic [13:0]        hum_centi;
		logic [15:0]        raw_t;
		logic [15:0]        raw_h;
		logic               t_ok;
		logic               h_ok;
		logic               both_ok;
	} reading_t;

	typedef struct {
		logic [7:0] data;
		bit         start;
		bit         typed;
		reading_t   want;
	} stim_row_t;

	localparam reading_t NO_WANT = '0;
	// 0xBEEF with its correct checksum 0x92.
	localparam reading_t WANT_BEEF_GOOD = '{temp_centi: 15'sd8552, hum_centi: 14'd7458,
		raw_t: 16'hBEEF, raw_h: 16'hBEEF, t_ok: 1'b1, h_ok: 1'b1, both_ok: 1'b1};
	localparam reading_t WANT_BEEF_TEMP_BAD = '{temp_centi: 15'sd8552, hum_centi: 14'd7458,
		raw_t: 16'hBEEF, raw_h: 16'hBEEF, t_ok: 1'b0, h_ok: 1'b1, both_ok: 1'b0};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte = 8'h00;
	logic               frame_start = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [14:0] temperature_centi_c;
	logic [13:0]        humidity_centi_pct;
	logic [15:0]        raw_temperature;
	logic [15:0]        raw_humidity;
	logic               temperature_crc_ok;
	logic               humidity_crc_ok;
	logic               frame_ok;

	humidity_sensor_frame_decoder dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.rx_byte             (rx_byte),
		.frame_start         (frame_start),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.temperature_centi_c (temperature_centi_c),
		.humidity_centi_pct  (humidity_centi_pct),
		.raw_temperature     (raw_temperature),
		.raw_humidity        (raw_humidity),
		.temperature_crc_ok  (temperature_crc_ok),
		.humidity_crc_ok     (humidity_crc_ok),
		.frame_ok            (frame_ok)
	);

	// Decoder state as the predictor sees it.
	byte_pos_t  pos_q       = POS_T_HI;
	logic [7:0] crc_q       = hsfd_pkg::CRC_INIT;
	logic [15:0] temp_word_q = 16'h0000;
	logic [15:0] hum_word_q  = 16'h0000;
	logic       temp_pass_q = 1'b0;

	reading_t   pending_readings[$];
	stim_row_t  directed[$];
	bit         in_calm = 1'b0;
	bit         out_calm = 1'b0;
	int         fail_count = 0;
	int         readings_checked = 0;
	int         bytes_sent = 0;
	int         frames_started = 0;
	int         cycles = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// Bit-serial CRC-8, MSB first.
	function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] data);
		logic fb;
		for (int k = 7; k >= 0; k--) begin
			fb  = acc[7] ^ data[k];
			acc = {acc[6:0], 1'b0};
			if (fb) begin
				acc = acc ^ hsfd_pkg::CRC_POLY;
			end
		end
		return acc;
	endfunction

	function automatic int pick_wait(input bit calm);
		if (calm || $urandom_range(0, 2) == 0) begin
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	function automatic logic [15:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 16'h0000;
		end
		if (r == 1) begin
			return 16'hFFFF;
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	// Advance the decoder state by one byte; report a reading after the humidity checksum.
	task automatic decode_byte(input logic [7:0] b, input bit fs, output bit produced,
			output reading_t r);
		byte_pos_t   p;
		logic [31:0] tprod;
		logic [31:0] hprod;
		logic [15:0] tdiff;
		logic        hum_pass;
		produced = 1'b0;
		r = '0;
		p = fs ? POS_T_HI : pos_q;
		case (p)
			POS_T_LO: begin
				crc_q = crc_fold(crc_q, b);
				temp_word_q[7:0] = b;
				pos_q = POS_T_CRC;
			end
			POS_T_CRC: begin
				temp_pass_q = (crc_q == b);
				crc_q = hsfd_pkg::CRC_INIT;
				pos_q = POS_H_HI;
			end
			POS_H_HI: begin
				crc_q = crc_fold(hsfd_pkg::CRC_INIT, b);
				hum_word_q = {b, 8'h00};
				pos_q = POS_H_LO;
			end
			POS_H_LO: begin
				crc_q = crc_fold(crc_q, b);
				hum_word_q[7:0] = b;
				pos_q = POS_H_CRC;
			end
			POS_H_CRC: begin
				hum_pass = (crc_q == b);
				tprod = {16'h0000, temp_word_q} * 32'd17500;
				hprod = {16'h0000, hum_word_q} * 32'd10000;
				tdiff = tprod[31:16] - 16'd4500;
				r.temp_centi = tdiff[14:0];
				r.hum_centi  = hprod[29:16];
				r.raw_t      = temp_word_q;
				r.raw_h      = hum_word_q;
				r.t_ok       = temp_pass_q;
				r.h_ok       = hum_pass;
				r.both_ok    = temp_pass_q & hum_pass;
				crc_q = hsfd_pkg::CRC_INIT;
				pos_q = POS_T_HI;
				produced = 1'b1;
			end
			default: begin
				crc_q = crc_fold(hsfd_pkg::CRC_INIT, b);
				temp_word_q = {b, 8'h00};
				pos_q = POS_T_LO;
			end
		endcase
	endtask

	// Entered and left at a falling edge; valid stays high on exit.
	task automatic send_transfer(input logic [7:0] b, input bit fs, input bit typed,
			input reading_t want);
		int       gap;
		bit       produced;
		reading_t r;
		gap = pick_wait(in_calm);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		frame_start = fs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		decode_byte(b, fs, produced, r);
		if (produced) begin
			pending_readings.push_back(typed ? want : r);
		end
		bytes_sent++;
		if (fs) begin
			frames_started++;
		end
		@(negedge clk);
		if ($urandom_range(0, 39) == 0) begin
			in_calm = !in_calm;
		end
	endtask

	task automatic add_row(input logic [7:0] b, input bit fs);
		directed.push_back(stim_row_t'{b, fs, 1'b0, NO_WANT});
	endtask

	task automatic add_frame(input logic [15:0] tw, input logic [7:0] tcrc,
			input logic [15:0] hw, input logic [7:0] hcrc, input bit lead_start,
			input bit typed, input reading_t want);
		add_row(tw[15:8], lead_start);
		add_row(tw[7:0], 1'b0);
		add_row(tcrc, 1'b0);
		add_row(hw[15:8], 1'b0);
		add_row(hw[7:0], 1'b0);
		directed.push_back(stim_row_t'{hcrc, 1'b0, typed, want});
	endtask

	task automatic check_reading(input reading_t got);
		reading_t want;
		if (pending_readings.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_BUDGET) begin
				$display("unexpected result: temp %0d hum %0d raw %h/%h",
					got.temp_centi, got.hum_centi, got.raw_t, got.raw_h);
			end
		end else begin
			want = pending_readings.pop_front();
			readings_checked++;
			if (want.temp_centi != got.temp_centi || want.hum_centi != got.hum_centi ||
					want.raw_t != got.raw_t || want.raw_h != got.raw_h ||
					want.t_ok != got.t_ok || want.h_ok != got.h_ok ||
					want.both_ok != got.both_ok) begin
				fail_count++;
				if (fail_count <= REPORT_BUDGET) begin
					$display("result %0d mismatch: expected temp %0d hum %0d raw %h/%h ok %b%b%b",
						readings_checked, want.temp_centi, want.hum_centi, want.raw_t,
						want.raw_h, want.t_ok, want.h_ok, want.both_ok);
					$display("    got temp %0d hum %0d raw %h/%h ok %b%b%b",
						got.temp_centi, got.hum_centi, got.raw_t, got.raw_h,
						got.t_ok, got.h_ok, got.both_ok);
				end
			end
		end
	endtask

	// Result side: draw a stall, then take one transfer.
	initial begin : result_sink
		int       stall;
		reading_t got;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = pick_wait(out_calm);
			if (stall > 0) begin
				out_stall = 1'b1;
				repeat (stall) @(negedge clk);
			end
			out_stall = 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got.temp_centi = temperature_centi_c;
			got.hum_centi  = humidity_centi_pct;
			got.raw_t      = raw_temperature;
			got.raw_h      = raw_humidity;
			got.t_ok       = temperature_crc_ok;
			got.h_ok       = humidity_crc_ok;
			got.both_ok    = frame_ok;
			check_reading(got);
			@(negedge clk);
			if ($urandom_range(0, 29) == 0) begin
				out_calm = !out_calm;
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles,
			pending_readings.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		logic [15:0] tw;
		logic [15:0] hw;
		logic [7:0]  frame[6];
		int          kind;
		int          len;
		bit          lead;

		add_frame(16'hBEEF, 8'h92, 16'hBEEF, 8'h92, 1'b1, 1'b1, WANT_BEEF_GOOD);
		add_frame(16'hBEEF, 8'h93, 16'hBEEF, 8'h92, 1'b1, 1'b1, WANT_BEEF_TEMP_BAD);
		// Partial frame, cut off by the start flag of the next one.
		add_row(8'h12, 1'b1);
		add_row(8'h34, 1'b0);
		add_frame(16'h0000, 8'h81, 16'h0000, 8'h00, 1'b1, 1'b0, NO_WANT);
		// No start flag: position wraps after the previous frame.
		add_frame(16'hFFFF, 8'hAC, 16'hFFFF, 8'h00, 1'b0, 1'b0, NO_WANT);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			send_transfer(directed[i].data, directed[i].start, directed[i].typed,
				directed[i].want);
		end

		while (bytes_sent < RANDOM_BYTES + directed.size()) begin
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				send_transfer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
					NO_WANT);
			end else begin
				tw = pick_word();
				hw = pick_word();
				frame[0] = tw[15:8];
				frame[1] = tw[7:0];
				frame[2] = crc_fold(crc_fold(hsfd_pkg::CRC_INIT, tw[15:8]), tw[7:0]);
				frame[3] = hw[15:8];
				frame[4] = hw[7:0];
				frame[5] = crc_fold(crc_fold(hsfd_pkg::CRC_INIT, hw[15:8]), hw[7:0]);
				if ($urandom_range(0, 4) == 0) begin
					frame[2] = frame[2] ^ 8'($urandom_range(1, 255));
				end
				if ($urandom_range(0, 4) == 0) begin
					frame[5] = frame[5] ^ 8'($urandom_range(1, 255));
				end
				len = (kind < 20) ? $urandom_range(1, 5) : 6;
				lead = ($urandom_range(0, 6) != 0);
				for (int k = 0; k < len; k++) begin
					send_transfer(frame[k], (k == 0) ? lead : 1'b0, 1'b0, NO_WANT);
				end
			end
		end
		in_valid = 1'b0;

		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes (%0d flagged frame starts), compared %0d results, %0d failures.",
			bytes_sent, frames_started, readings_checked, fail_count);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[humidity_sensor_frame_decoder.f]
rtl/core/hsfd_pkg.sv
rtl/core/hsfd_front.sv
rtl/core/hsfd_queue.sv
rtl/core/hsfd_convert.sv
rtl/core/humidity_sensor_frame_decoder.sv
tb/tb_humidity_sensor_frame_decoder.sv
